// ===== hw/rtl/swjt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// swjt_pkg
// Shared types and constants for the store watch and jump trace unit.
// ----------------------------------------------------------------------------
package swjt_pkg;

    localparam int unsigned CfgIdxW = 3;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_WRITE_BASE  = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_WRITE_SIZE  = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_JUMP_BASE   = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_JUMP_SIZE   = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_MAX_RECORDS = 3'd4;

    // event and record kinds
    localparam logic OP_STORE   = 1'b0;
    localparam logic OP_FETCH   = 1'b1;
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_JUMP  = 1'b1;

    localparam logic [31:0] MIRROR_MASK  = 32'h1fff_ffff;
    localparam logic [30:0] COUNT_MAX    = 31'h7fff_ffff;
    localparam logic [31:0] PC_STEP      = 32'd2;   // sequential fetch step
    localparam logic [31:0] STORE_PC_ADJ = 32'd2;   // store pc is already advanced

    // per-kind record counter status
    typedef struct packed {
        logic stopped;   // kind has reached its cap
        logic reach;     // a record counted now reaches the cap
    } cnt_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/store_watch_and_jump_trace.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// store_watch_and_jump_trace
// Store watchpoint and branch trace: matches store and fetch events against
// two address windows and emits write and jump records with per-kind caps.
// ----------------------------------------------------------------------------
//
//  channel | handshake             | payload
//  --------+-----------------------+--------------------------------------------
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//  in      | in_valid  / in_ready  | op, address, store_size, store_value,
//          |                       | store_pc, timestamp
//  out     | out_valid / out_ready | kind, from_pc, target, rec_size,
//          |                       | rec_value, rec_cycle, limit_reached
//
//  One item per cycle sustained unless the output stalls. In the input register
//  an item's window compares and counter updates are evaluated, and its record
//  (if any) is registered into the result register when the item advances.
//  Reset clears config, counters, stop flags and fetch history; no clear pass.
//  An output stall holds the result register; the input register still drains
//  into it as soon as out_ready takes the waiting record. cfg_ready is always 1.
// ----------------------------------------------------------------------------
module store_watch_and_jump_trace
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    // configuration writes
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [swjt_pkg::CfgIdxW-1:0]  cfg_index,
    input  wire logic [31:0]                   cfg_data,

    // event items
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          op,
    input  wire logic [31:0]                   address,
    input  wire logic [3:0]                    store_size,
    input  wire logic [63:0]                   store_value,
    input  wire logic [31:0]                   store_pc,
    input  wire logic [63:0]                   timestamp,

    // record items
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               kind,
    output logic [31:0]                        from_pc,
    output logic [31:0]                        target,
    output logic [3:0]                         rec_size,
    output logic [63:0]                        rec_value,
    output logic [63:0]                        rec_cycle,
    output logic                               limit_reached
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [31:0] write_base_reg;
    logic [31:0] write_size_reg;
    logic [31:0] jump_base_reg;
    logic [31:0] jump_size_reg;
    logic [30:0] max_records_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_base_reg  <= '0;
            write_size_reg  <= '0;
            jump_base_reg   <= '0;
            jump_size_reg   <= '0;
            max_records_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                swjt_pkg::CFG_WRITE_BASE:  write_base_reg  <= cfg_data;
                swjt_pkg::CFG_WRITE_SIZE:  write_size_reg  <= cfg_data;
                swjt_pkg::CFG_JUMP_BASE:   jump_base_reg   <= cfg_data;
                swjt_pkg::CFG_JUMP_SIZE:   jump_size_reg   <= cfg_data;
                swjt_pkg::CFG_MAX_RECORDS: max_records_reg <= cfg_data[30:0];
                default:                   ;   // unknown index: dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // input register
    // ------------------------------------------------------------------
    logic        in_valid_reg;
    logic        op_reg;
    logic [31:0] address_reg;
    logic [3:0]  store_size_reg;
    logic [63:0] store_value_reg;
    logic [31:0] store_pc_reg;
    logic [63:0] timestamp_reg;

    logic        advance;     // item in input register resolves this cycle
    logic        out_free;    // result register can take a new record

    assign out_free = !out_valid || out_ready;
    assign advance  = in_valid_reg && out_free;
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg          <= op;
            address_reg     <= address;
            store_size_reg  <= store_size;
            store_value_reg <= store_value;
            store_pc_reg    <= store_pc;
            timestamp_reg   <= timestamp;
        end
    end

    // ------------------------------------------------------------------
    // window match
    // ------------------------------------------------------------------
    logic in_write_win;
    logic in_jump_win;

    swjt_win u_write_win
    (
        .addr (address_reg),
        .base (write_base_reg),
        .size (write_size_reg),
        .hit  (in_write_win)
    );

    swjt_win u_jump_win
    (
        .addr (address_reg),
        .base (jump_base_reg),
        .size (jump_size_reg),
        .hit  (in_jump_win)
    );

    // ------------------------------------------------------------------
    // fetch history and record decision
    // ------------------------------------------------------------------
    logic        prev_inside_reg;
    logic [31:0] prev_fetch_pc_reg;

    swjt_pkg::cnt_stat_t write_stat;
    swjt_pkg::cnt_stat_t jump_stat;

    logic write_hit;
    logic jump_hit;
    logic write_rec;
    logic jump_rec;

    assign write_hit = (op_reg == swjt_pkg::OP_STORE) && !write_stat.stopped && in_write_win;

    // leaving the code window by a discontinuity
    assign jump_hit  = (op_reg == swjt_pkg::OP_FETCH) && !jump_stat.stopped
                       && prev_inside_reg && !in_jump_win
                       && (address_reg != (prev_fetch_pc_reg + swjt_pkg::PC_STEP));

    assign write_rec = advance && write_hit;
    assign jump_rec  = advance && jump_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_inside_reg   <= 1'b0;
            prev_fetch_pc_reg <= '0;
        end
        else if (advance && (op_reg == swjt_pkg::OP_FETCH))
        begin
            prev_inside_reg   <= in_jump_win;
            prev_fetch_pc_reg <= address_reg;
        end
    end

    swjt_count u_write_cnt
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .rec         (write_rec),
        .max_records (max_records_reg),
        .stat        (write_stat)
    );

    swjt_count u_jump_cnt
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .rec         (jump_rec),
        .max_records (max_records_reg),
        .stat        (jump_stat)
    );

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= write_rec || jump_rec;
        end
    end

    always_ff @(posedge clk)
    begin
        if (write_rec)
        begin
            kind          <= swjt_pkg::KIND_WRITE;
            from_pc       <= store_pc_reg - swjt_pkg::STORE_PC_ADJ;
            target        <= address_reg;
            rec_size      <= store_size_reg;
            rec_value     <= store_value_reg;
            rec_cycle     <= timestamp_reg;
            limit_reached <= write_stat.reach;
        end
        else if (jump_rec)
        begin
            kind          <= swjt_pkg::KIND_JUMP;
            from_pc       <= prev_fetch_pc_reg;
            target        <= address_reg;
            rec_size      <= '0;
            rec_value     <= '0;
            rec_cycle     <= timestamp_reg;
            limit_reached <= jump_stat.reach;
        end
    end

    assign out_valid = out_valid_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        !(write_rec && jump_rec))
        else $error("write and jump record in the same cycle");

    a_write_stop: assert property (@(posedge clk) disable iff (!rst_n)
        write_rec && write_stat.reach |=> write_stat.stopped && !write_rec)
        else $error("write kind did not stop at its cap");

    a_jump_stop: assert property (@(posedge clk) disable iff (!rst_n)
        jump_rec && jump_stat.reach |=> jump_stat.stopped && !jump_rec)
        else $error("jump kind did not stop at its cap");

    a_jump_from: assert property (@(posedge clk) disable iff (!rst_n)
        jump_rec |=> out_valid && (kind == swjt_pkg::KIND_JUMP)
                     && (from_pc == $past(prev_fetch_pc_reg)))
        else $error("jump record lost its previous pc");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with an empty result register");

endmodule
`default_nettype wire

// ===== hw/rtl/swjt_win.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// swjt_win
// Address window match, direct and with the top three bits masked.
// ----------------------------------------------------------------------------
module swjt_win
(
    input  wire logic [31:0] addr,
    input  wire logic [31:0] base,
    input  wire logic [31:0] size,
    output logic             hit
);

    logic [31:0] off_direct;
    logic [31:0] off_mirror;

    assign off_direct = addr - base;
    assign off_mirror = (addr & swjt_pkg::MIRROR_MASK) - (base & swjt_pkg::MIRROR_MASK);
    assign hit        = (off_direct < size) || (off_mirror < size);

endmodule
`default_nettype wire

// ===== hw/rtl/swjt_count.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// swjt_count
// Saturating record counter with cap flag and sticky stop.
// ----------------------------------------------------------------------------
module swjt_count
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               rec,          // one record counted this cycle
    input  wire logic [30:0]        max_records,
    output swjt_pkg::cnt_stat_t     stat
);

    logic [30:0] count_reg;
    logic [30:0] count_next;
    logic        stopped_reg;
    logic        stopped_next;
    logic [30:0] count_inc;
    logic        reach;

    // saturate at all ones
    assign count_inc = (count_reg < swjt_pkg::COUNT_MAX) ? (count_reg + 31'd1) : count_reg;

    always_comb
    begin
        count_next   = count_reg;
        stopped_next = stopped_reg;
        if (rec)
        begin
            count_next = count_inc;
            if (reach)
            begin
                stopped_next = 1'b1;
            end
        end
    end

    assign reach = (max_records != 31'd0) && (count_inc >= max_records);
    assign stat  = '{stopped: stopped_reg, reach: reach};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            stopped_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            stopped_reg <= stopped_next;
        end
    end

endmodule
`default_nettype wire
